### rtl/vmst_pkg.sv
// vmst_pkg: shared types and codes for the valid-masked slot table
// no dependencies; used by the controller, datapath and top level
package vmst_pkg;

  // item actions
  typedef enum logic [2:0] {
    ACT_WRITE  = 3'd0,
    ACT_READ   = 3'd1,
    ACT_INVAL  = 3'd2,
    ACT_ADD    = 3'd3,
    ACT_REMOVE = 3'd4,
    ACT_MEMBER = 3'd5
  } action_t;

  // trend codes
  localparam logic signed [1:0] TREND_FLAT = 2'sb00;
  localparam logic signed [1:0] TREND_RISE = 2'sb01;
  localparam logic signed [1:0] TREND_FALL = 2'sb11;

  // controller to datapath commands
  typedef struct packed {
    logic clr_step;  // write an empty entry at the sweep index
    logic start;     // latch the input transaction, reset accumulators
    logic issue;     // read the entry at the sweep index
    logic load;      // move the accumulated result to the output register
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic idx_last;  // sweep index sits on the last slot
  } sts_t;

endpackage

### rtl/vmst_if.sv
// vmst_if: valid/ready channel interfaces for input and result transactions
// depends on nothing; field widths follow the item definitions
interface vmst_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         action;
  logic [3:0]         slot;
  logic signed [31:0] value;

  modport source (output valid, output action, output slot, output value, input ready);
  modport sink   (input valid, input action, input slot, input value, output ready);
endinterface

interface vmst_out_if;
  logic               valid;
  logic               ready;
  logic               ok;
  logic signed [31:0] read_value;
  logic [3:0]         placed_slot;
  logic [4:0]         valid_count;
  logic signed [1:0]  trend;

  modport source (output valid, output ok, output read_value, output placed_slot,
                  output valid_count, output trend, input ready);
  modport sink   (input valid, input ok, input read_value, input placed_slot,
                  input valid_count, input trend, output ready);
endinterface

### rtl/valid_masked_slot_table.sv
// valid_masked_slot_table: one transaction at a time, each one scanning every slot once
// the result register loads in ST_FINISH, after ST_SCAN and ST_DRAIN, once the output is free
// the scan reads one slot memory entry a cycle; no new transaction is taken until the result loads
// reset: synchronous rst_n; a clearing pass empties every slot,
// with in_ready low until it ends; the result register lets the next item start early
module valid_masked_slot_table #(
  parameter int CAPACITY = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  vmst_in_if.sink    in_ch,
  vmst_out_if.source out_ch
);

  vmst_pkg::cmd_t cmd;
  vmst_pkg::sts_t sts;

  // control
  vmst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // datapath
  vmst_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_action       (in_ch.action),
    .in_slot         (in_ch.slot),
    .in_value        (in_ch.value),
    .out_ok          (out_ch.ok),
    .out_read_value  (out_ch.read_value),
    .out_placed_slot (out_ch.placed_slot),
    .out_valid_count (out_ch.valid_count),
    .out_trend       (out_ch.trend)
  );

endmodule

### rtl/vmst_ctrl.sv
// vmst_ctrl: sequencing state machine for the slot table
// depends on vmst_pkg (cmd_t, sts_t)
module vmst_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output vmst_pkg::cmd_t cmd,
  input  vmst_pkg::sts_t sts
);

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_SCAN   = 5'b00100,
    ST_DRAIN  = 5'b01000,
    ST_FINISH = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign in_ready  = (state_r == ST_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.idx_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.issue = 1'b1;
        if (sts.idx_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd.load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // output valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) out_valid_nxt = 1'b0;
    if (cmd.load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### rtl/vmst_dp.sv
// vmst_dp: slot memory, sweep index and per-slot update and trend accumulators
// depends on vmst_pkg (cmd_t, sts_t, action and trend codes)
module vmst_dp #(
  parameter int CAPACITY = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  vmst_pkg::cmd_t     cmd,
  output vmst_pkg::sts_t     sts,
  input  logic [2:0]         in_action,
  input  logic [3:0]         in_slot,
  input  logic signed [31:0] in_value,
  output logic               out_ok,
  output logic signed [31:0] out_read_value,
  output logic [3:0]         out_placed_slot,
  output logic [4:0]         out_valid_count,
  output logic signed [1:0]  out_trend
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  typedef struct packed {
    logic               vld;
    logic signed [31:0] val;
  } entry_t;

  // slot storage
  entry_t slot_mem_r [CAPACITY];
  entry_t rdata_r;

  // sweep index and read pipeline
  logic [AW-1:0] idx_r, idx_nxt;
  logic          idx_last;
  logic          proc_vld_r;
  logic [AW-1:0] proc_idx_r;

  // latched transaction
  logic [2:0]         act_r;
  logic [3:0]         slot_r;
  logic signed [31:0] val_r;

  // accumulators
  logic               ok_r, ok_nxt;
  logic signed [31:0] rd_r, rd_nxt;
  logic [3:0]         placed_r, placed_nxt;
  logic               placed_done_r, placed_done_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic               have_prev_r, have_prev_nxt;
  logic               rising_r, rising_nxt;
  logic               falling_r, falling_nxt;
  logic signed [31:0] prev_r, prev_nxt;

  // per-slot update
  entry_t new_entry;
  logic   wb_en;
  logic   hit;
  logic   eq;

  // memory write port and trend result
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t        mem_wdata;
  logic signed [1:0] trend;

  assign idx_last     = (idx_r == AW'(CAPACITY - 1));
  assign sts.idx_last = idx_last;

  // sweep index: shared by the clearing pass and the item scan
  always_comb begin
    idx_nxt = idx_r;
    if (cmd.clr_step || cmd.issue) idx_nxt = idx_last ? '0 : idx_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r      <= '0;
      proc_vld_r <= 1'b0;
    end else begin
      idx_r      <= idx_nxt;
      proc_vld_r <= cmd.issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) proc_idx_r <= idx_r;
  end

  // slot memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) slot_mem_r[mem_waddr] <= mem_wdata;
    if (cmd.issue) rdata_r <= slot_mem_r[idx_r];
  end

  // transaction latch
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      act_r  <= in_action;
      slot_r <= in_slot;
      val_r  <= in_value;
    end
  end

  // apply the action to one slot, then fold it into count and trend
  always_comb begin
    ok_nxt          = ok_r;
    rd_nxt          = rd_r;
    placed_nxt      = placed_r;
    placed_done_nxt = placed_done_r;
    cnt_nxt         = cnt_r;
    have_prev_nxt   = have_prev_r;
    rising_nxt      = rising_r;
    falling_nxt     = falling_r;
    prev_nxt        = prev_r;
    new_entry       = rdata_r;
    wb_en           = 1'b0;
    hit             = (32'(slot_r) == 32'(proc_idx_r));
    eq              = (rdata_r.val == val_r);
    if (proc_vld_r) begin
      case (act_r)
        vmst_pkg::ACT_WRITE: begin
          if (hit) begin
            new_entry.vld = 1'b1;
            new_entry.val = val_r;
            wb_en         = 1'b1;
            ok_nxt        = 1'b1;
          end
        end
        vmst_pkg::ACT_READ: begin
          if (hit && rdata_r.vld) begin
            rd_nxt = rdata_r.val;
            ok_nxt = 1'b1;
          end
        end
        vmst_pkg::ACT_INVAL: begin
          if (hit && rdata_r.vld) begin
            new_entry.vld = 1'b0;
            wb_en         = 1'b1;
            ok_nxt        = 1'b1;
          end
        end
        vmst_pkg::ACT_ADD: begin
          if (!rdata_r.vld && !placed_done_r) begin
            new_entry.vld   = 1'b1;
            new_entry.val   = val_r;
            wb_en           = 1'b1;
            placed_nxt      = 4'(proc_idx_r);
            placed_done_nxt = 1'b1;
            ok_nxt          = 1'b1;
          end
        end
        vmst_pkg::ACT_REMOVE: begin
          if (rdata_r.vld && eq) begin
            new_entry.vld = 1'b0;
            wb_en         = 1'b1;
            ok_nxt        = 1'b1;
          end
        end
        vmst_pkg::ACT_MEMBER: begin
          if (rdata_r.vld && eq) ok_nxt = 1'b1;
        end
        default: ;
      endcase
      // trend and count over the slot as it stands after the action
      if (new_entry.vld) begin
        if (have_prev_r) begin
          if (!(prev_r < new_entry.val)) rising_nxt = 1'b0;
          if (!(new_entry.val < prev_r)) falling_nxt = 1'b0;
        end
        prev_nxt      = new_entry.val;
        have_prev_nxt = 1'b1;
        cnt_nxt       = cnt_r + 1'b1;
      end
    end
    if (cmd.start) begin
      ok_nxt          = 1'b0;
      rd_nxt          = '0;
      placed_nxt      = '0;
      placed_done_nxt = 1'b0;
      cnt_nxt         = '0;
      have_prev_nxt   = 1'b0;
      rising_nxt      = 1'b1;
      falling_nxt     = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    ok_r          <= ok_nxt;
    rd_r          <= rd_nxt;
    placed_r      <= placed_nxt;
    placed_done_r <= placed_done_nxt;
    cnt_r         <= cnt_nxt;
    have_prev_r   <= have_prev_nxt;
    rising_r      <= rising_nxt;
    falling_r     <= falling_nxt;
    prev_r        <= prev_nxt;
  end

  // memory write: clearing pass or write-back of a changed slot
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = proc_idx_r;
    mem_wdata = new_entry;
    if (cmd.clr_step) begin
      mem_we    = 1'b1;
      mem_waddr = idx_r;
      mem_wdata = '0;
    end else if (proc_vld_r && wb_en) begin
      mem_we = 1'b1;
    end
  end

  // final trend code
  always_comb begin
    trend = vmst_pkg::TREND_FLAT;
    if (cnt_r >= CW'(2)) begin
      if (rising_r) trend = vmst_pkg::TREND_RISE;
      else if (falling_r) trend = vmst_pkg::TREND_FALL;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_ok          <= ok_r;
      out_read_value  <= rd_r;
      out_placed_slot <= placed_r;
      out_valid_count <= 5'(cnt_r);
      out_trend       <= trend;
    end
  end

endmodule

### rtl/vmst_checker.sv
// vmst_checker: port-level assertions for the slot table, with its bind
// depends on valid_masked_slot_table port names only
module vmst_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic              out_ok,
  input logic signed [31:0] out_read_value,
  input logic [3:0]        out_placed_slot,
  input logic signed [1:0] out_trend
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_value) && $stable(out_ok))
    else $error("result changed while stalled");

  // one transaction at a time: ready drops after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted during a scan");

  // read data only on success
  a_read_needs_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_read_value != 32'sd0) |-> out_ok)
    else $error("read data without success");

  // placed slot only on success
  a_place_needs_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_placed_slot != 4'd0) |-> out_ok)
    else $error("placed slot without success");

  // trend code is never the unused value
  a_trend_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_trend != 2'sb10)
    else $error("bad trend code");

endmodule

bind valid_masked_slot_table vmst_checker u_vmst_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_ok          (out_ch.ok),
  .out_read_value  (out_ch.read_value),
  .out_placed_slot (out_ch.placed_slot),
  .out_trend       (out_ch.trend)
);
